FILE: rtl/nlms_pkg.sv
// Shared widths and constants for the normalized LMS adaptive FIR filter.
package nlms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 32;
    localparam int ACC_W      = 64;
    localparam int POWER_W    = 40;
    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 32;
    localparam int MUL_A_W    = 49;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = 64;
    localparam int DIVISOR_W  = 41;
    localparam int DIV_STEPS  = 46;
    localparam int DIV_CNT_W  = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
    localparam logic [0:0] REG_STEP_GAIN = 1'b0;

endpackage

FILE: rtl/nlms_mac.sv
// Shared signed multiplier with a registered product.
module nlms_mac (
    input  logic                                clk,
    input  logic signed [nlms_pkg::MUL_A_W-1:0] a,
    input  logic signed [nlms_pkg::MUL_B_W-1:0] b,
    output logic signed [nlms_pkg::PROD_W-1:0]  prod
);

    logic signed [nlms_pkg::PROD_W-1:0] prod_reg;
    logic signed [nlms_pkg::PROD_W-1:0] prod_next;

    assign prod_next = nlms_pkg::PROD_W'(a) * nlms_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/nlms_div.sv
// Restoring divider: quotient of gain * 2^46 over the divisor, one bit a cycle.
module nlms_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [nlms_pkg::GAIN_W-1:0]         gain,
    input  logic [nlms_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                done,
    output logic [nlms_pkg::STEP_W-1:0]         quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [nlms_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [nlms_pkg::DIVISOR_W-1:0]      rem_reg;
    logic [nlms_pkg::DIVISOR_W-1:0]      den_reg;
    logic [nlms_pkg::STEP_W-1:0]         quo_reg;
    logic [nlms_pkg::DIVISOR_W:0]        trial;
    logic [nlms_pkg::DIVISOR_W:0]        diff;
    logic                                fits;

    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nlms_pkg::DIV_CNT_W'(nlms_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder stays below the divisor, so one shifted bit suffices.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= nlms_pkg::DIVISOR_W'(gain);
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[nlms_pkg::DIVISOR_W-1:0] : trial[nlms_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[nlms_pkg::STEP_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/nlms_adaptive_fir_filter.sv
// Top level: normalized LMS adaptive FIR noise canceller with a shared MAC.
//
//  channel   signals                                     direction
//  -------   ------------------------------------------  ---------
//  input     in_valid/in_stall, reference/desired_sample in
//  output    out_valid/out_stall, error_sample/clipped   out
//  config    APB psel/penable/pwrite/paddr/pwdata/prdata in/out
//
// Each item takes a filter pass over the shared MAC and,
// on every UPDATE_EVERY-th item, also a power update, a
// 46-step divide and a weight pass through the same MAC.
// After reset both memories are swept to zero; no transfer is taken
// during the sweep. A finished result waits in the output register
// while the next item is taken; a stalled output only holds the
// block once the following result is ready.
module nlms_adaptive_fir_filter #(
    parameter int TAPS         = 128,
    parameter int UPDATE_EVERY = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [nlms_pkg::SAMPLE_W-1:0]  reference_sample,
    input  logic signed [nlms_pkg::SAMPLE_W-1:0]  desired_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [nlms_pkg::SAMPLE_W-1:0]  error_sample,
    output logic                                  error_clipped,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nlms_pkg::PADDR_W-1:0]          paddr,
    input  logic [nlms_pkg::PDATA_W-1:0]          pwdata,
    output logic [nlms_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    localparam int HIST_DEPTH = TAPS + 1;
    localparam int HAW = $clog2(HIST_DEPTH);
    localparam int WAW = $clog2(TAPS);
    localparam int PHW = (UPDATE_EVERY > 1) ? $clog2(UPDATE_EVERY) : 1;
    localparam logic [HAW-1:0] HIST_LAST = HAW'(TAPS);
    localparam logic [PHW-1:0] PH_LAST   = PHW'(UPDATE_EVERY - 1);
    localparam int SW = nlms_pkg::SAMPLE_W;
    localparam int AW = nlms_pkg::MUL_A_W;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FILT, ST_ERR, ST_PRD, ST_SQO, ST_SQN,
        ST_PWR, ST_DIV, ST_ESM, ST_ESC, ST_UPD, ST_DONE
    } state_t;

    // Storage
    logic signed [SW-1:0]                   hist_mem [HIST_DEPTH];
    logic signed [nlms_pkg::WEIGHT_W-1:0]   wgt_mem  [TAPS];
    logic signed [SW-1:0]                   hist_rd_reg;
    logic signed [nlms_pkg::WEIGHT_W-1:0]   wgt_rd_reg;

    // Control state
    state_t                         state_reg, state_next;
    logic [HAW-1:0]                 clr_reg, clr_next;
    logic [HAW-1:0]                 wp_reg, wp_next;
    logic [HAW-1:0]                 hp_reg, hp_next;
    logic [HAW-1:0]                 iss_reg, iss_next;
    logic                           v1_reg, v2_reg;
    logic [PHW-1:0]                 phase_reg, phase_next;
    logic [nlms_pkg::POWER_W-1:0]   power_reg, power_next;
    logic [nlms_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic                           out_valid_reg, out_valid_next;

    // Datapath registers
    logic [WAW-1:0]                         k1_reg, k2_reg;
    logic signed [nlms_pkg::WEIGHT_W-1:0]   w2_reg;
    logic signed [nlms_pkg::ACC_W-1:0]      acc_reg;
    logic signed [SW-1:0]                   x_reg, d_reg, e_reg;
    logic                                   clip_reg;
    logic [30:0]                            sq_old_reg;
    logic signed [AW-1:0]                   es_reg;
    logic signed [SW-1:0]                   out_e_reg;
    logic                                   out_clip_reg;

    // Combinational
    logic                                   accept, issue, stream_done, out_load, cfg_write;
    logic [HAW-1:0]                         wp_inc, hist_raddr, hist_waddr, hp_dec;
    logic                                   hist_we, wgt_we;
    logic signed [SW-1:0]                   hist_wdata;
    logic [WAW-1:0]                         wgt_waddr;
    logic signed [nlms_pkg::WEIGHT_W-1:0]   wgt_wdata;
    logic signed [AW-1:0]                   mac_a;
    logic signed [SW-1:0]                   mac_b;
    logic signed [nlms_pkg::PROD_W-1:0]     mac_p;
    logic signed [nlms_pkg::ACC_W-1:0]      acc_rnd;
    logic signed [35:0]                     y_val;
    logic signed [36:0]                     diff;
    logic signed [SW-1:0]                   e_sat;
    logic                                   e_clip;
    logic [35:0]                            old_term, new_term;
    logic signed [45:0]                     p_sum;
    logic [nlms_pkg::POWER_W-1:0]           p_clamp;
    logic [nlms_pkg::DIVISOR_W-1:0]         divisor;
    logic                                   div_start, div_done;
    logic [nlms_pkg::STEP_W-1:0]            div_q;
    logic signed [nlms_pkg::PROD_W-1:0]     upd_rnd;
    logic signed [29:0]                     delta;
    logic signed [33:0]                     wsum;
    logic signed [nlms_pkg::WEIGHT_W-1:0]   w_sat;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_write = psel && penable && pwrite && pready;

    assign wp_inc = (wp_reg == HIST_LAST) ? '0 : wp_reg + 1'b1;
    assign hp_dec = (hp_reg == '0) ? HIST_LAST : hp_reg - 1'b1;

    assign issue = ((state_reg == ST_FILT) || (state_reg == ST_UPD)) && (iss_reg != HIST_LAST);
    assign stream_done = (iss_reg == HIST_LAST) && !v1_reg && !v2_reg;

    // Memory ports: the oldest sample sits right after the newest one.
    assign hist_raddr = (state_reg == ST_PRD) ? wp_inc : hp_reg;
    assign hist_we    = (state_reg == ST_CLEAR) || accept;
    assign hist_waddr = (state_reg == ST_CLEAR) ? clr_reg : wp_inc;
    assign hist_wdata = (state_reg == ST_CLEAR) ? '0 : reference_sample;

    assign wgt_we    = ((state_reg == ST_CLEAR) && (clr_reg != HIST_LAST))
                     || ((state_reg == ST_UPD) && v2_reg);
    assign wgt_waddr = (state_reg == ST_CLEAR) ? clr_reg[WAW-1:0] : k2_reg;
    assign wgt_wdata = (state_reg == ST_CLEAR) ? '0 : w_sat;

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_waddr] <= wgt_wdata;
        end
        wgt_rd_reg <= wgt_mem[iss_reg[WAW-1:0]];
    end

    // Shared multiplier operand select
    always_comb
    begin
        mac_a = '0;
        mac_b = '0;
        case (state_reg)
            ST_FILT:
            begin
                mac_a = {{(AW - nlms_pkg::WEIGHT_W){wgt_rd_reg[nlms_pkg::WEIGHT_W-1]}}, wgt_rd_reg};
                mac_b = hist_rd_reg;
            end
            ST_UPD:
            begin
                mac_a = es_reg;
                mac_b = hist_rd_reg;
            end
            ST_SQO:
            begin
                mac_a = {{(AW - SW){hist_rd_reg[SW-1]}}, hist_rd_reg};
                mac_b = hist_rd_reg;
            end
            ST_SQN:
            begin
                mac_a = {{(AW - SW){x_reg[SW-1]}}, x_reg};
                mac_b = x_reg;
            end
            ST_ESM:
            begin
                mac_a = {{(AW - nlms_pkg::STEP_W){1'b0}}, div_q};
                mac_b = e_reg;
            end
            default:
            begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    nlms_mac u_mac (
        .clk  (clk),
        .a    (mac_a),
        .b    (mac_b),
        .prod (mac_p)
    );

    // Round the filter output to Q15 and saturate the error.
    assign acc_rnd = acc_reg + (nlms_pkg::ACC_W'(1) <<< 27);
    assign y_val   = acc_rnd[63:28];
    assign diff    = {{21{d_reg[SW-1]}}, d_reg} - {y_val[35], y_val};

    always_comb
    begin
        e_sat  = diff[SW-1:0];
        e_clip = 1'b0;
        if (!diff[36] && (diff[35:15] != '0))
        begin
            e_sat  = 16'sh7FFF;
            e_clip = 1'b1;
        end
        else if (diff[36] && (diff[35:15] != '1))
        begin
            e_sat  = -16'sh8000;
            e_clip = 1'b1;
        end
    end

    // Windowed power: drop the oldest square, add the newest, clamp.
    assign old_term = 36'(sq_old_reg) * 36'(UPDATE_EVERY);
    assign new_term = 36'(mac_p[30:0]) * 36'(UPDATE_EVERY);
    assign p_sum = $signed({6'd0, power_reg}) - $signed({10'd0, old_term})
                 + $signed({10'd0, new_term});

    always_comb
    begin
        if (p_sum[45])
        begin
            p_clamp = '0;
        end
        else if (p_sum[44:40] != '0)
        begin
            p_clamp = '1;
        end
        else
        begin
            p_clamp = p_sum[39:0];
        end
    end

    assign divisor   = {1'b0, p_clamp} + (nlms_pkg::DIVISOR_W'(1) << 30);
    assign div_start = (state_reg == ST_PWR);

    nlms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .gain     (gain_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Weight update: round the Q62 delta to Q28 and saturate.
    assign upd_rnd = mac_p + (nlms_pkg::PROD_W'(1) <<< 33);
    assign delta   = upd_rnd[63:34];
    assign wsum    = {{2{w2_reg[31]}}, w2_reg} + {{4{delta[29]}}, delta};

    always_comb
    begin
        if (wsum[33:31] == 3'b000 || wsum[33:31] == 3'b111)
        begin
            w_sat = wsum[31:0];
        end
        else if (wsum[33])
        begin
            w_sat = 32'sh8000_0000;
        end
        else
        begin
            w_sat = 32'sh7FFF_FFFF;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        hp_next        = hp_reg;
        iss_next       = iss_reg;
        phase_next     = phase_reg;
        power_next     = power_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        if (cfg_write && (paddr[2] == nlms_pkg::REG_STEP_GAIN))
        begin
            gain_next = pwdata[nlms_pkg::GAIN_W-1:0];
        end
        if (issue)
        begin
            iss_next = iss_reg + 1'b1;
            hp_next  = hp_dec;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == HIST_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    wp_next    = wp_inc;
                    hp_next    = wp_inc;
                    iss_next   = '0;
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                if (stream_done)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                state_next = (phase_reg == '0) ? ST_PRD : ST_DONE;
            end
            ST_PRD: state_next = ST_SQO;
            ST_SQO: state_next = ST_SQN;
            ST_SQN: state_next = ST_PWR;
            ST_PWR:
            begin
                power_next = p_clamp;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ESM;
                end
            end
            ST_ESM: state_next = ST_ESC;
            ST_ESC:
            begin
                iss_next   = '0;
                hp_next    = wp_reg;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (stream_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            hp_reg        <= '0;
            iss_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            phase_reg     <= '0;
            power_reg     <= '0;
            gain_reg      <= nlms_pkg::GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            hp_reg        <= hp_next;
            iss_reg       <= iss_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            phase_reg     <= phase_next;
            power_reg     <= power_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k1_reg <= iss_reg[WAW-1:0];
        k2_reg <= k1_reg;
        w2_reg <= wgt_rd_reg;
        if (accept)
        begin
            x_reg   <= reference_sample;
            d_reg   <= desired_sample;
            acc_reg <= '0;
        end
        else if ((state_reg == ST_FILT) && v2_reg)
        begin
            acc_reg <= acc_reg + mac_p;
        end
        if (state_reg == ST_ERR)
        begin
            e_reg    <= e_sat;
            clip_reg <= e_clip;
        end
        if (state_reg == ST_SQN)
        begin
            sq_old_reg <= mac_p[30:0];
        end
        if (state_reg == ST_ESC)
        begin
            es_reg <= mac_p[AW-1:0];
        end
        if (out_load)
        begin
            out_e_reg    <= e_reg;
            out_clip_reg <= clip_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign error_sample  = out_e_reg;
    assign error_clipped = out_clip_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == nlms_pkg::REG_STEP_GAIN)
                         ? nlms_pkg::PDATA_W'(gain_reg) : '0;

endmodule

FILE: sim/tb.sv
// Testbench for the normalized LMS adaptive FIR filter with a bit-exact predictor.
`timescale 1ns / 100ps

module tb;

    localparam int TAPS         = 128;
    localparam int UPDATE_EVERY = 4;
    localparam int DRAIN_CYCLES = 2 * TAPS + 80;
    localparam int HOLD_CYCLES  = 3000;

    localparam int SAMPLE_W = nlms_pkg::SAMPLE_W;
    localparam int WEIGHT_W = nlms_pkg::WEIGHT_W;
    localparam int POWER_W  = nlms_pkg::POWER_W;
    localparam int GAIN_W   = nlms_pkg::GAIN_W;
    localparam int PADDR_W  = nlms_pkg::PADDR_W;
    localparam int PDATA_W  = nlms_pkg::PDATA_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] err;
        logic                       clip;
    } error_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SAMPLE_W-1:0] reference_sample = '0;
    logic signed [SAMPLE_W-1:0] desired_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] error_sample;
    logic error_clipped;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    nlms_adaptive_fir_filter #(
        .TAPS         (TAPS),
        .UPDATE_EVERY (UPDATE_EVERY)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .reference_sample (reference_sample),
        .desired_sample   (desired_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .error_sample     (error_sample),
        .error_clipped    (error_clipped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 clk = ~clk;

    // Predictor state: mirrors the delay line, weights, power window and gain
    logic signed [SAMPLE_W-1:0] pred_history [0:TAPS];
    logic signed [WEIGHT_W-1:0] pred_weights [0:TAPS-1];
    logic [POWER_W-1:0]         pred_power;
    int                         pred_phase;
    logic [GAIN_W-1:0]          pred_gain;

    error_result_t expected_errors [$];
    int mismatches = 0;

    // Idle percentages for each side; hold-off requests and the ones served
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Work out one error result and advance the predictor state
    function automatic error_result_t predict_error(input logic signed [SAMPLE_W-1:0] x,
                                                    input logic signed [SAMPLE_W-1:0] d);
        error_result_t r;
        longint acc;
        longint y;
        longint e;
        longint p;
        longint xn;
        longint xo;
        longint ex;
        longint delta;
        longint w;
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] stepv;
        acc = 0;
        for (int k = TAPS; k > 0; k--)
            pred_history[k] = pred_history[k-1];
        pred_history[0] = x;
        for (int k = 0; k < TAPS; k++)
            acc += longint'(pred_weights[k]) * longint'(pred_history[k]);
        y = (acc + (longint'(1) << 27)) >>> 28;
        e = longint'(d) - y;
        r.clip = 1'b0;
        if (e > 32767)
        begin
            e = 32767;
            r.clip = 1'b1;
        end
        if (e < -32768)
        begin
            e = -32768;
            r.clip = 1'b1;
        end
        r.err = e[SAMPLE_W-1:0];
        if (pred_phase == 0)
        begin
            xn = pred_history[0];
            xo = pred_history[TAPS];
            p = longint'({24'b0, pred_power}) - xo * xo * UPDATE_EVERY
                + xn * xn * UPDATE_EVERY;
            // clamp the window sum at both ends
            if (p < 0)
                p = 0;
            if (p > ((longint'(1) << 40) - 1))
                p = (longint'(1) << 40) - 1;
            pred_power = p[POWER_W-1:0];
            numer = {48'b0, pred_gain} << 46;
            denom = (64'd1 << 30) + {24'b0, pred_power};
            stepv = numer / denom;
            for (int k = 0; k < TAPS; k++)
            begin
                ex = e * longint'(pred_history[k]);
                delta = (ex * longint'(stepv) + (longint'(1) << 33)) >>> 34;
                w = longint'(pred_weights[k]) + delta;
                if (w > 64'sd2147483647)
                    w = 64'sd2147483647;
                if (w < -64'sd2147483648)
                    w = -64'sd2147483648;
                pred_weights[k] = w[WEIGHT_W-1:0];
            end
        end
        pred_phase = (pred_phase + 1) % UPDATE_EVERY;
        return r;
    endfunction

    // Offer one item, with random idle cycles first; hold until the transfer
    task automatic send_item(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        reference_sample <= x;
        desired_sample <= d;
        do
            @(posedge clk);
        while (in_stall);
        expected_errors.push_back(predict_error(x, d));
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected result has arrived, then let the block settle
    task automatic wait_drained();
        while (expected_errors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == PADDR_W'(4 * nlms_pkg::REG_STEP_GAIN))
            pred_gain = data[GAIN_W-1:0];
        @(posedge clk);
    endtask

    task automatic apb_check_gain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'(4 * nlms_pkg::REG_STEP_GAIN);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[GAIN_W-1:0] !== pred_gain)
            report_mismatch("step_gain readback", prdata[GAIN_W-1:0], pred_gain);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random sample: full range, small amplitude, or an extreme
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return $signed(16'($urandom_range(2047))) - 16'sd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_sample(), random_sample());
        end_burst();
    endtask

    // Check each accepted result
    always @(posedge clk)
    begin
        error_result_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_errors.size() == 0)
                report_mismatch("unexpected result", error_sample, 0);
            else
            begin
                want = expected_errors.pop_front();
                if (error_sample !== want.err)
                    report_mismatch("error_sample", error_sample, want.err);
                if (error_clipped !== want.clip)
                    report_mismatch("error_clipped", error_clipped, want.clip);
            end
        end
    end

    // Drive the receiver stall: random idling, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic test_directed();
        send_item(16'sh0000, 16'sh0000);
        send_item(16'sh7FFF, 16'sh7FFF);
        send_item(16'sh8000, 16'sh8000);
        send_item(16'sh7FFF, 16'sh8000);
        send_item(16'sh8000, 16'sh7FFF);
        send_item(16'shFFFF, 16'sh0001);
        send_item(16'sh0001, 16'shFFFF);
        send_item(16'sh5555, 16'shAAAA);
        send_item(16'shAAAA, 16'sh5555);
        for (int i = 0; i < 14; i++)
            send_item((i % 2) ? 16'sh8000 : 16'sh7FFF, (i % 3) ? 16'sh7FFF : 16'sh8000);
        end_burst();
        wait_drained();
    endtask

    // Go through gain settings, extremes among them; an out-of-range index is ignored
    task automatic test_gain_settings();
        logic [GAIN_W-1:0] gains [4];
        gains[0] = 16'd0;
        gains[1] = 16'hFFFF;
        gains[2] = 16'd1;
        gains[3] = 16'($urandom);
        foreach (gains[g])
        begin
            apb_write(PADDR_W'(4 * nlms_pkg::REG_STEP_GAIN), {16'($urandom), gains[g]});
            apb_write(PADDR_W'(4), 32'($urandom));
            apb_check_gain();
            send_random(150);
            wait_drained();
        end
        apb_write(PADDR_W'(4 * nlms_pkg::REG_STEP_GAIN), 32'(nlms_pkg::GAIN_RESET));
        apb_check_gain();
    endtask

    task automatic test_random_idling();
        send_idle_pct = 13;
        recv_idle_pct = 52;
        send_random(350);
        send_idle_pct = 52;
        recv_idle_pct = 13;
        send_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(350);
        wait_drained();
    endtask

    // Hold the output off long enough that the block fills and stalls its input
    task automatic test_backpressure();
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        send_random(30);
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int k = 0; k <= TAPS; k++)
            pred_history[k] = '0;
        for (int k = 0; k < TAPS; k++)
            pred_weights[k] = '0;
        pred_power = '0;
        pred_phase = 0;
        pred_gain = nlms_pkg::GAIN_RESET;
        @(posedge clk);
        test_directed();
        test_gain_settings();
        test_random_idling();
        test_backpressure();
        if (mismatches == 0 && expected_errors.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/nlms_pkg.sv
rtl/nlms_mac.sv
rtl/nlms_div.sv
rtl/nlms_adaptive_fir_filter.sv
sim/tb.sv
